// ===== design/gn3d_pkg.sv =====
// gn3d_pkg: shared constants and types of the 3d gradient noise block
package gn3d_pkg;

  localparam int TABLE_SIZE  = 256;
  localparam int IDX_W       = $clog2(TABLE_SIZE);
  localparam int FRAC_BITS   = 16;
  localparam int GRAD_W      = 16;
  localparam int PT_W        = 32;
  localparam int OUT_W       = 16;
  localparam int OUT_FRAC    = 14;
  localparam int OUT_SHIFT   = GRAD_W - 2 + FRAC_BITS - OUT_FRAC;
  localparam int NUM_AXES    = 3;
  localparam int NUM_CORNERS = 8;
  localparam int NUM_STAGES  = 8;

  localparam int W_W      = FRAC_BITS + 1;
  localparam int OFF_W    = FRAC_BITS + 2;
  localparam int PROD_W   = GRAD_W + OFF_W;
  localparam int DOTSUM_W = PROD_W + 2;
  localparam int DOT_W    = DOTSUM_W - FRAC_BITS;
  localparam int TERM_W   = DOT_W + W_W + 1;
  localparam int ACC_W    = TERM_W + 3;
  localparam int GRAD_ENT_W = 3 * GRAD_W;

  typedef enum logic {
    MODE_LOAD = 1'b0,
    MODE_EVAL = 1'b1
  } mode_e;

  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [FRAC_BITS-1:0] frac_t;
  typedef logic [W_W-1:0]       weight_t;

  typedef struct packed {
    logic signed [GRAD_W-1:0] x;
    logic signed [GRAD_W-1:0] y;
    logic signed [GRAD_W-1:0] z;
  } grad_t;

endpackage

// ===== design/gn3d_if.sv =====
// gn3d_if: input and output channel interfaces of the noise block
interface gn3d_in_if;
  logic                                      valid;
  logic                                      ready;
  gn3d_pkg::mode_e                           mode;
  logic        [gn3d_pkg::IDX_W-1:0]         table_index;
  logic        [gn3d_pkg::IDX_W-1:0]         perm_x_value;
  logic        [gn3d_pkg::IDX_W-1:0]         perm_y_value;
  logic        [gn3d_pkg::IDX_W-1:0]         perm_z_value;
  logic signed [gn3d_pkg::GRAD_W-1:0]        grad_x;
  logic signed [gn3d_pkg::GRAD_W-1:0]        grad_y;
  logic signed [gn3d_pkg::GRAD_W-1:0]        grad_z;
  logic signed [gn3d_pkg::PT_W-1:0]          point_x;
  logic signed [gn3d_pkg::PT_W-1:0]          point_y;
  logic signed [gn3d_pkg::PT_W-1:0]          point_z;

  modport source (
    output valid, mode, table_index, perm_x_value, perm_y_value, perm_z_value,
    output grad_x, grad_y, grad_z, point_x, point_y, point_z,
    input  ready
  );
  modport sink (
    input  valid, mode, table_index, perm_x_value, perm_y_value, perm_z_value,
    input  grad_x, grad_y, grad_z, point_x, point_y, point_z,
    output ready
  );
endinterface

interface gn3d_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [gn3d_pkg::OUT_W-1:0]  noise_value;

  modport source (output valid, noise_value, input ready);
  modport sink (input valid, noise_value, output ready);
endinterface

// ===== design/gn3d_ram.sv =====
// gn3d_ram: generic ram, one write port, two registered read ports
module gn3d_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ===== design/gn3d_lookup.sv =====
// gn3d_lookup: permutation tables, corner hash and gradient table reads
module gn3d_lookup (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic                we_i,
  input  gn3d_pkg::idx_t      widx_i,
  input  gn3d_pkg::idx_t      wperm_i [gn3d_pkg::NUM_AXES],
  input  gn3d_pkg::grad_t     wgrad_i,
  input  gn3d_pkg::idx_t      cell_i  [gn3d_pkg::NUM_AXES],
  output gn3d_pkg::grad_t     grad_o  [gn3d_pkg::NUM_CORNERS]
);

  localparam int NUM_GRAM = gn3d_pkg::NUM_CORNERS / 2;

  logic [gn3d_pkg::IDX_W-1:0]      perm_lo [gn3d_pkg::NUM_AXES];
  logic [gn3d_pkg::IDX_W-1:0]      perm_hi [gn3d_pkg::NUM_AXES];
  gn3d_pkg::idx_t                  hash    [gn3d_pkg::NUM_CORNERS];
  logic [gn3d_pkg::GRAD_ENT_W-1:0] grd_a   [NUM_GRAM];
  logic [gn3d_pkg::GRAD_ENT_W-1:0] grd_b   [NUM_GRAM];

  for (genvar a = 0; a < gn3d_pkg::NUM_AXES; a++) begin : g_perm
    gn3d_ram #(
      .WIDTH (gn3d_pkg::IDX_W),
      .DEPTH (gn3d_pkg::TABLE_SIZE)
    ) u_perm (
      .clk_i     (clk_i),
      .we_i      (we_i),
      .waddr_i   (widx_i),
      .wdata_i   (wperm_i[a]),
      .re_i      (en_i),
      .raddr_a_i (cell_i[a]),
      .raddr_b_i (cell_i[a] + gn3d_pkg::idx_t'(1)),
      .rdata_a_o (perm_lo[a]),
      .rdata_b_o (perm_hi[a])
    );
  end

  // corner bits: x is bit 2, y bit 1, z bit 0 of the corner number
  always_comb begin
    for (int d = 0; d < gn3d_pkg::NUM_CORNERS; d++) begin
      hash[d] = (d[2] ? perm_hi[0] : perm_lo[0])
              ^ (d[1] ? perm_hi[1] : perm_lo[1])
              ^ (d[0] ? perm_hi[2] : perm_lo[2]);
    end
  end

  for (genvar k = 0; k < NUM_GRAM; k++) begin : g_grad
    gn3d_ram #(
      .WIDTH (gn3d_pkg::GRAD_ENT_W),
      .DEPTH (gn3d_pkg::TABLE_SIZE)
    ) u_grad (
      .clk_i     (clk_i),
      .we_i      (we_i),
      .waddr_i   (widx_i),
      .wdata_i   (wgrad_i),
      .re_i      (en_i),
      .raddr_a_i (hash[2*k]),
      .raddr_b_i (hash[2*k+1]),
      .rdata_a_o (grd_a[k]),
      .rdata_b_o (grd_b[k])
    );
    assign grad_o[2*k]   = gn3d_pkg::grad_t'(grd_a[k]);
    assign grad_o[2*k+1] = gn3d_pkg::grad_t'(grd_b[k]);
  end

endmodule

// ===== design/gn3d_weight.sv =====
// gn3d_weight: fade curve and trilinear corner weights pipeline
module gn3d_weight (
  input  logic                clk_i,
  input  logic                en_i,
  input  gn3d_pkg::frac_t     frac_i [gn3d_pkg::NUM_AXES],
  output gn3d_pkg::frac_t     frac_o [gn3d_pkg::NUM_AXES],
  output gn3d_pkg::weight_t   wt_o   [gn3d_pkg::NUM_CORNERS]
);

  localparam int F    = gn3d_pkg::FRAC_BITS;
  localparam int WW   = gn3d_pkg::W_W;
  localparam int SQ_W = 2 * F;
  localparam int WP_W = 2 * WW;
  localparam int FD_W = F + 3;
  localparam logic signed [FD_W-1:0] OneS = FD_W'(1) <<< F;
  localparam gn3d_pkg::weight_t      One  = WW'(1) << F;

  gn3d_pkg::frac_t   t1_q  [gn3d_pkg::NUM_AXES];
  gn3d_pkg::frac_t   t2_q  [gn3d_pkg::NUM_AXES];
  gn3d_pkg::frac_t   t1b_q [gn3d_pkg::NUM_AXES];
  gn3d_pkg::frac_t   t2b_q [gn3d_pkg::NUM_AXES];
  gn3d_pkg::frac_t   t3_q  [gn3d_pkg::NUM_AXES];
  gn3d_pkg::weight_t fd_q  [gn3d_pkg::NUM_AXES];
  gn3d_pkg::weight_t fz_q;
  gn3d_pkg::weight_t wxy_q [4];
  gn3d_pkg::weight_t wt_q  [gn3d_pkg::NUM_CORNERS];

  gn3d_pkg::frac_t   t2_d  [gn3d_pkg::NUM_AXES];
  gn3d_pkg::frac_t   t3_d  [gn3d_pkg::NUM_AXES];
  gn3d_pkg::weight_t fd_d  [gn3d_pkg::NUM_AXES];
  gn3d_pkg::weight_t wxy_d [4];
  gn3d_pkg::weight_t wt_d  [gn3d_pkg::NUM_CORNERS];

  logic [SQ_W-1:0]         sq;
  logic [SQ_W-1:0]         cu;
  logic signed [FD_W-1:0]  fr;
  gn3d_pkg::weight_t       wa;
  gn3d_pkg::weight_t       wb;
  logic [WP_W-1:0]         wp;
  logic [WP_W-1:0]         wq;

  always_comb begin
    for (int a = 0; a < gn3d_pkg::NUM_AXES; a++) begin
      sq = SQ_W'(frac_i[a]) * SQ_W'(frac_i[a]);
      t2_d[a] = sq[SQ_W-1:F];
      cu = SQ_W'(t2_q[a]) * SQ_W'(t1_q[a]);
      t3_d[a] = cu[SQ_W-1:F];
      fr = FD_W'(signed'({1'b0, t2b_q[a]})) * FD_W'(3)
         - FD_W'(signed'({1'b0, t3_q[a]})) * FD_W'(2);
      if (fr < 0) begin
        fd_d[a] = '0;
      end else if (fr > OneS) begin
        fd_d[a] = One;
      end else begin
        fd_d[a] = fr[WW-1:0];
      end
    end
    for (int c = 0; c < 4; c++) begin
      wa = c[1] ? fd_q[0] : One - fd_q[0];
      wb = c[0] ? fd_q[1] : One - fd_q[1];
      wp = WP_W'(wa) * WP_W'(wb);
      wxy_d[c] = wp[F+WW-1:F];
    end
    for (int d = 0; d < gn3d_pkg::NUM_CORNERS; d++) begin
      wa = d[0] ? fz_q : One - fz_q;
      wq = WP_W'(wxy_q[d/2]) * WP_W'(wa);
      wt_d[d] = wq[F+WW-1:F];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t1_q  <= frac_i;
      t2_q  <= t2_d;
      t1b_q <= t1_q;
      t2b_q <= t2_q;
      t3_q  <= t3_d;
      fd_q  <= fd_d;
      fz_q  <= fd_q[2];
      wxy_q <= wxy_d;
      wt_q  <= wt_d;
    end
  end

  assign frac_o = t1b_q;
  assign wt_o   = wt_q;

endmodule

// ===== design/gn3d_blend.sv =====
// gn3d_blend: corner dot products, weighting, sum and saturation
module gn3d_blend (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  gn3d_pkg::grad_t                    grad_i [gn3d_pkg::NUM_CORNERS],
  input  gn3d_pkg::frac_t                    frac_i [gn3d_pkg::NUM_AXES],
  input  gn3d_pkg::weight_t                  wt_i   [gn3d_pkg::NUM_CORNERS],
  output logic signed [gn3d_pkg::OUT_W-1:0]  noise_o
);

  localparam int F    = gn3d_pkg::FRAC_BITS;
  localparam int OW   = gn3d_pkg::OFF_W;
  localparam int PW   = gn3d_pkg::PROD_W;
  localparam int SW   = gn3d_pkg::DOTSUM_W;
  localparam int DW   = gn3d_pkg::DOT_W;
  localparam int TW   = gn3d_pkg::TERM_W;
  localparam int AW   = gn3d_pkg::ACC_W;
  localparam int NC   = gn3d_pkg::NUM_CORNERS;
  localparam int NA   = gn3d_pkg::NUM_AXES;
  localparam logic signed [OW-1:0] OneOff = OW'(1) <<< F;
  localparam logic signed [AW-1:0] SatHi  = AW'((1 << (gn3d_pkg::OUT_W - 1)) - 1);
  localparam logic signed [AW-1:0] SatLo  = -AW'(1 << (gn3d_pkg::OUT_W - 1));

  logic signed [PW-1:0] prod_q [NC][NA];
  logic signed [DW-1:0] dot_q  [NC];
  logic signed [DW-1:0] dot5_q [NC];
  logic signed [TW-1:0] term_q [NC];
  logic signed [AW-1:0] acc_q;
  logic signed [gn3d_pkg::OUT_W-1:0] noise_q;

  logic signed [PW-1:0] prod_d [NC][NA];
  logic signed [DW-1:0] dot_d  [NC];
  logic signed [TW-1:0] term_d [NC];
  logic signed [AW-1:0] acc_d;
  logic signed [gn3d_pkg::OUT_W-1:0] noise_d;

  logic signed [OW-1:0]            off;
  logic signed [gn3d_pkg::GRAD_W-1:0] g;
  logic signed [SW-1:0]            dsum;
  logic signed [SW-1:0]            dsh;
  logic signed [gn3d_pkg::W_W:0]   wts;
  logic signed [AW-1:0]            res;

  always_comb begin
    for (int d = 0; d < NC; d++) begin
      for (int a = 0; a < NA; a++) begin
        g = (a == 0) ? grad_i[d].x : ((a == 1) ? grad_i[d].y : grad_i[d].z);
        off = OW'(signed'({2'b00, frac_i[a]}));
        if (d[2-a]) begin
          off = off - OneOff;
        end
        prod_d[d][a] = PW'(g) * PW'(off);
      end
      dsum = SW'(prod_q[d][0]) + SW'(prod_q[d][1]) + SW'(prod_q[d][2]);
      dsh = dsum >>> F;
      dot_d[d] = dsh[DW-1:0];
      wts = signed'({1'b0, wt_i[d]});
      term_d[d] = TW'(dot5_q[d]) * TW'(wts);
    end
    acc_d = '0;
    for (int d = 0; d < NC; d++) begin
      acc_d = acc_d + AW'(term_q[d]);
    end
    res = acc_q >>> gn3d_pkg::OUT_SHIFT;
    if (res > SatHi) begin
      noise_d = SatHi[gn3d_pkg::OUT_W-1:0];
    end else if (res < SatLo) begin
      noise_d = SatLo[gn3d_pkg::OUT_W-1:0];
    end else begin
      noise_d = res[gn3d_pkg::OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q  <= prod_d;
      dot_q   <= dot_d;
      dot5_q  <= dot_q;
      term_q  <= term_d;
      acc_q   <= acc_d;
      noise_q <= noise_d;
    end
  end

  assign noise_o = noise_q;

endmodule

// ===== design/gradient_noise_3d_top.sv =====
// gradient_noise_3d_top: 3d gradient noise evaluator with loadable tables
// A load beat (mode 0) writes one entry of the three permutation tables and
// of the gradient table and gives no result; an evaluate beat (mode 1) takes
// a Q16.16 point and gives one Q2.14 saturated noise value. One beat is
// taken every cycle that the pipeline advances; the eight-stage pipeline (two
// registered table reads, then fade, dot product, weighting and summation
// stages) advances whenever its output register is empty or being taken.
// The tables are not cleared by reset, so evaluate only after loading every
// entry that the points in use can reach.
module gradient_noise_3d_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  gn3d_in_if.sink      in_i,
  gn3d_out_if.source   out_o
);

  localparam int F  = gn3d_pkg::FRAC_BITS;
  localparam int IW = gn3d_pkg::IDX_W;
  localparam int NS = gn3d_pkg::NUM_STAGES;

  logic                 en;
  logic                 acc_in;
  logic [NS-1:0]        vld_q;
  logic [NS-1:0]        vld_d;
  gn3d_pkg::idx_t       lat_idx[gn3d_pkg::NUM_AXES];
  gn3d_pkg::idx_t       wperm  [gn3d_pkg::NUM_AXES];
  gn3d_pkg::frac_t      frac   [gn3d_pkg::NUM_AXES];
  gn3d_pkg::frac_t      frac_s2[gn3d_pkg::NUM_AXES];
  gn3d_pkg::grad_t      wgrad;
  gn3d_pkg::grad_t      grad   [gn3d_pkg::NUM_CORNERS];
  gn3d_pkg::weight_t    wt     [gn3d_pkg::NUM_CORNERS];
  logic signed [gn3d_pkg::OUT_W-1:0] noise;

  assign en         = !vld_q[NS-1] || out_o.ready;
  assign in_i.ready = en;
  assign acc_in     = in_i.valid && en;

  assign lat_idx[0] = in_i.point_x[F+IW-1:F];
  assign lat_idx[1] = in_i.point_y[F+IW-1:F];
  assign lat_idx[2] = in_i.point_z[F+IW-1:F];
  assign frac[0]  = in_i.point_x[F-1:0];
  assign frac[1]  = in_i.point_y[F-1:0];
  assign frac[2]  = in_i.point_z[F-1:0];
  assign wperm[0] = in_i.perm_x_value;
  assign wperm[1] = in_i.perm_y_value;
  assign wperm[2] = in_i.perm_z_value;
  assign wgrad    = '{x: in_i.grad_x, y: in_i.grad_y, z: in_i.grad_z};

  assign vld_d = {vld_q[NS-2:0], acc_in && (in_i.mode == gn3d_pkg::MODE_EVAL)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= vld_d;
    end
  end

  gn3d_lookup u_lookup (
    .clk_i   (clk_i),
    .en_i    (en),
    .we_i    (acc_in && (in_i.mode == gn3d_pkg::MODE_LOAD)),
    .widx_i  (in_i.table_index),
    .wperm_i (wperm),
    .wgrad_i (wgrad),
    .cell_i  (lat_idx),
    .grad_o  (grad)
  );

  gn3d_weight u_weight (
    .clk_i  (clk_i),
    .en_i   (en),
    .frac_i (frac),
    .frac_o (frac_s2),
    .wt_o   (wt)
  );

  gn3d_blend u_blend (
    .clk_i   (clk_i),
    .en_i    (en),
    .grad_i  (grad),
    .frac_i  (frac_s2),
    .wt_i    (wt),
    .noise_o (noise)
  );

  assign out_o.valid       = vld_q[NS-1];
  assign out_o.noise_value = noise;

endmodule
